### hdl/first_fit_block_allocator_unit_defines.svh
// Assertion macros for the first-fit allocator checker.
// No dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hdl/ffa_pkg.sv
// Package for the first-fit allocator: payload types, status codes, constants.
// No dependencies.
package ffa_pkg;
	localparam int MaxSegments = 64;
	localparam int OffsetBits = 16;
	localparam int HdrDepth = 1 << OffsetBits;
	localparam logic [15:0] HdrBytes = 16'd2;
	localparam logic [15:0] MinPayload = 16'd4;
	localparam logic [15:0] RefusedSize = 16'hFFFF;
	localparam logic [15:0] EvenMask = 16'hFFFE;
	localparam logic [15:0] ArenaReset = 16'd16384;
	localparam logic [15:0] ArenaMin = 16'd16;
	localparam logic [7:0] WasteReset = 8'd16;
	localparam logic [7:0] WasteMin = 8'd4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BADADDR = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic {
		REG_ARENA = 1'b0,
		REG_WASTE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic operation;
		logic [15:0] request_bytes;
		logic [15:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] granted_offset;
		logic [15:0] granted_bytes;
		logic arena_all_free;
	} rsp_t;
endpackage

### hdl/ffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/first_fit_block_allocator_unit.sv
// Top level of the first-fit allocator: sequencer over the segment table RAM
// and the header RAM. Depends on ffa_pkg and ffa_ram.
//
//  channel   signals                          handshake
//  command   start, busy, req                 in, accepted at start & !busy
//  result    done, rsp                        out, one-cycle strobe
//  config    cfg_we, cfg_index, cfg_data      in, written at any edge with cfg_we
//
// Allocate: a read and a check state per table entry searched, then four
// header byte writes on a split, or entries moved down when taken whole.
// Free: a header read through S_FH0, S_FH1 and S_FH2, the same walk, one
// resolve state, then header writes and entry moves.
// Reset and a REG_ARENA write clear the header store one byte a cycle,
// with busy high throughout. The receiver cannot stall.
module first_fit_block_allocator_unit
	import ffa_pkg::*;
#(
	parameter int MAX_SEGMENTS = ffa_pkg::MaxSegments
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ffa_pkg::req_t req,
	output logic done,
	output ffa_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

	typedef enum logic [17:0] {
		S_INIT  = 18'b000000000000000001,
		S_CLR   = 18'b000000000000000010,
		S_IDLE  = 18'b000000000000000100,
		S_ARD   = 18'b000000000000001000,
		S_ACHK  = 18'b000000000000010000,
		S_FH0   = 18'b000000000000100000,
		S_FH1   = 18'b000000000001000000,
		S_FH2   = 18'b000000000010000000,
		S_FRD   = 18'b000000000100000000,
		S_FCHK  = 18'b000000001000000000,
		S_FRES  = 18'b000000010000000000,
		S_SDRD  = 18'b000000100000000000,
		S_SDWR  = 18'b000001000000000000,
		S_SURD  = 18'b000010000000000000,
		S_SUWR  = 18'b000100000000000000,
		S_HWR   = 18'b001000000000000000,
		S_FIN   = 18'b010000000000000000,
		S_DONE  = 18'b100000000000000000
	} state_t;

	state_t state_q;
	logic [15:0] arena_q;
	logic [7:0] waste_q;
	logic [CW-1:0] count_q, idx_q, k_q;
	logic [15:0] x_q, h_q, s_q;
	logic [7:0] lo_q;
	logic [15:0] prev_st_q, prev_by_q, cur_st_q, cur_by_q;
	logic have_prev_q, have_cur_q;
	logic [15:0] hw_addr_q, hw_val_q, hw2_addr_q, hw2_val_q;
	logic hw_two_q, hstep_q, shift_pend_q, init_q;
	logic [OffsetBits-1:0] clr_q;
	status_t status_q;
	logic [15:0] goff_q, gbytes_q;
	logic done_q;
	rsp_t rsp_q;

	// table RAM: {start, bytes}
	logic t_we;
	logic [IW-1:0] t_waddr, t_raddr;
	logic [31:0] t_wdata, t_rdata;
	// header RAM: one byte per arena address
	logic h_we;
	logic [OffsetBits-1:0] h_waddr, h_raddr;
	logic [7:0] h_wdata, h_rdata;

	ffa_ram #(.Width(32), .Depth(MAX_SEGMENTS)) u_tab (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);
	ffa_ram #(.Width(8), .Depth(HdrDepth)) u_hdr (
		.clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	logic [15:0] eff_arena;
	logic [7:0] eff_waste;
	logic [15:0] t_st, t_by;
	assign eff_arena = (arena_q < ArenaMin) ? ArenaMin : arena_q;
	assign eff_waste = (waste_q < WasteMin) ? WasteMin : waste_q;
	assign t_st = t_rdata[31:16];
	assign t_by = t_rdata[15:0];

	logic [15:0] xs;
	always_comb begin
		xs = req.request_bytes + 16'd1;
		if (xs < MinPayload) xs = MinPayload;
		xs = xs & EvenMask;
	end

	logic refuse, bad_addr;
	assign refuse = (req.request_bytes == RefusedSize) || (count_q == '0);
	assign bad_addr = (req.block_offset < HdrBytes) ||
		((req.block_offset - HdrBytes) >= eff_arena);

	logic [15:0] n_by, new_st;
	assign n_by = t_by - x_q;
	assign new_st = t_st + x_q + HdrBytes;

	logic left_hit, right_hit;
	assign left_hit = have_prev_q && ({2'b00, prev_st_q} + {2'b00, prev_by_q} +
		{2'b00, HdrBytes} == {2'b00, h_q});
	assign right_hit = have_cur_q && ({2'b00, cur_st_q} ==
		{2'b00, h_q} + {2'b00, s_q} + {2'b00, HdrBytes});

	logic [15:0] sum_lr, sum_l, sum_r;
	assign sum_lr = prev_by_q + s_q + HdrBytes + cur_by_q + HdrBytes;
	assign sum_l = prev_by_q + s_q + HdrBytes;
	assign sum_r = s_q + HdrBytes + cur_by_q;

	logic all_free;
	assign all_free = (count_q != '0) &&
		({1'b0, t_by} + {1'b0, HdrBytes} == {1'b0, eff_arena});

	always_comb begin
		t_we = 1'b0;
		t_waddr = idx_q[IW-1:0];
		t_wdata = '0;
		t_raddr = idx_q[IW-1:0];
		h_we = 1'b0;
		h_waddr = hw_addr_q;
		h_wdata = hw_val_q[7:0];
		h_raddr = h_q;
		unique case (state_q)
		S_INIT: begin
			t_we = 1'b1;
			t_waddr = '0;
			t_wdata = {16'd0, eff_arena - HdrBytes};
		end
		S_CLR: begin
			h_we = 1'b1;
			h_waddr = clr_q;
			h_wdata = 8'd0;
		end
		S_ACHK: begin
			if (t_by >= x_q && n_by > {8'd0, eff_waste}) begin
				t_we = 1'b1;
				t_wdata = {new_st, n_by - HdrBytes};
			end
		end
		S_FH1: h_raddr = h_q + 16'd1;
		S_FRES: begin
			if (left_hit) begin
				t_we = 1'b1;
				t_waddr = IW'(idx_q - CW'(1));
				t_wdata = {prev_st_q, right_hit ? sum_lr : sum_l};
			end else if (right_hit) begin
				t_we = 1'b1;
				t_wdata = {h_q, sum_r};
			end
		end
		S_SDRD: t_raddr = IW'(k_q + CW'(1));
		S_SDWR, S_SUWR: begin
			t_we = 1'b1;
			t_waddr = IW'(k_q);
			t_wdata = t_rdata;
		end
		S_SURD: begin
			t_raddr = IW'(k_q - CW'(1));
			if (k_q <= idx_q) begin
				t_we = 1'b1;
				t_wdata = {h_q, s_q};
			end
		end
		S_HWR: begin
			h_we = 1'b1;
			h_waddr = hw_addr_q + {15'd0, hstep_q};
			h_wdata = hstep_q ? hw_val_q[15:8] : hw_val_q[7:0];
		end
		S_FIN: t_raddr = '0;
		default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			arena_q <= ArenaReset;
			waste_q <= WasteReset;
			count_q <= CW'(1);
			idx_q <= '0;
			k_q <= '0;
			x_q <= '0;
			h_q <= '0;
			s_q <= '0;
			lo_q <= '0;
			prev_st_q <= '0;
			prev_by_q <= '0;
			cur_st_q <= '0;
			cur_by_q <= '0;
			have_prev_q <= 1'b0;
			have_cur_q <= 1'b0;
			hw_addr_q <= '0;
			hw_val_q <= '0;
			hw2_addr_q <= '0;
			hw2_val_q <= '0;
			hw_two_q <= 1'b0;
			hstep_q <= 1'b0;
			shift_pend_q <= 1'b0;
			init_q <= 1'b0;
			clr_q <= '0;
			status_q <= ST_OK;
			goff_q <= '0;
			gbytes_q <= '0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			if (cfg_we && cfg_index == REG_WASTE) waste_q <= cfg_data[7:0];
			if (cfg_we && cfg_index == REG_ARENA) begin
				arena_q <= cfg_data;
				state_q <= S_INIT;
			end else begin
				unique case (state_q)
				S_INIT: begin
					count_q <= CW'(1);
					clr_q <= '0;
					state_q <= S_CLR;
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						hw_addr_q <= 16'd0;
						hw_val_q <= eff_arena - HdrBytes;
						hw_two_q <= 1'b0;
						shift_pend_q <= 1'b0;
						init_q <= 1'b1;
						state_q <= S_HWR;
					end
				end
				S_IDLE: begin
					if (start && !busy) begin
						idx_q <= '0;
						have_prev_q <= 1'b0;
						have_cur_q <= 1'b0;
						goff_q <= '0;
						gbytes_q <= '0;
						shift_pend_q <= 1'b0;
						hw_two_q <= 1'b0;
						x_q <= xs;
						h_q <= req.block_offset - HdrBytes;
						if (req.operation == 1'b0) begin
							if (refuse) begin
								status_q <= ST_NOFIT;
								state_q <= S_FIN;
							end else begin
								status_q <= ST_OK;
								state_q <= S_ARD;
							end
						end else if (bad_addr) begin
							status_q <= ST_BADADDR;
							state_q <= S_FIN;
						end else begin
							status_q <= ST_OK;
							state_q <= S_FH0;
						end
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (t_by >= x_q) begin
						goff_q <= t_st + HdrBytes;
						if (n_by > {8'd0, eff_waste}) begin
							gbytes_q <= x_q;
							hw_addr_q <= new_st;
							hw_val_q <= n_by - HdrBytes;
							hw2_addr_q <= t_st;
							hw2_val_q <= x_q;
							hw_two_q <= 1'b1;
							state_q <= S_HWR;
						end else begin
							gbytes_q <= t_by;
							k_q <= idx_q;
							state_q <= S_SDRD;
						end
					end else if (idx_q + CW'(1) >= count_q) begin
						status_q <= ST_NOFIT;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_ARD;
					end
				end
				S_FH0: state_q <= S_FH1;
				S_FH1: begin
					lo_q <= h_rdata;
					state_q <= S_FH2;
				end
				S_FH2: begin
					s_q <= {h_rdata, lo_q};
					state_q <= S_FRD;
				end
				S_FRD: begin
					if (idx_q >= count_q) begin
						have_cur_q <= 1'b0;
						state_q <= S_FRES;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (t_st < h_q) begin
						prev_st_q <= t_st;
						prev_by_q <= t_by;
						have_prev_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
						state_q <= S_FRD;
					end else begin
						cur_st_q <= t_st;
						cur_by_q <= t_by;
						have_cur_q <= 1'b1;
						state_q <= S_FRES;
					end
				end
				S_FRES: begin
					if (left_hit && right_hit) begin
						hw_addr_q <= prev_st_q;
						hw_val_q <= sum_lr;
						k_q <= idx_q;
						shift_pend_q <= 1'b1;
						state_q <= S_HWR;
					end else if (left_hit) begin
						hw_addr_q <= prev_st_q;
						hw_val_q <= sum_l;
						state_q <= S_HWR;
					end else if (right_hit) begin
						hw_addr_q <= h_q;
						hw_val_q <= sum_r;
						state_q <= S_HWR;
					end else if (count_q >= CMAX) begin
						status_q <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						k_q <= count_q;
						state_q <= S_SURD;
					end
				end
				S_SDRD: begin
					if (k_q + CW'(1) < count_q) begin
						state_q <= S_SDWR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SDWR: begin
					k_q <= k_q + CW'(1);
					state_q <= S_SDRD;
				end
				S_SURD: begin
					if (k_q > idx_q) begin
						state_q <= S_SUWR;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SUWR: begin
					k_q <= k_q - CW'(1);
					state_q <= S_SURD;
				end
				S_HWR: begin
					hstep_q <= ~hstep_q;
					if (hstep_q) begin
						if (hw_two_q) begin
							hw_two_q <= 1'b0;
							hw_addr_q <= hw2_addr_q;
							hw_val_q <= hw2_val_q;
						end else if (init_q) begin
							init_q <= 1'b0;
							state_q <= S_IDLE;
						end else if (shift_pend_q) begin
							shift_pend_q <= 1'b0;
							state_q <= S_SDRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					rsp_q <= '{status: status_q, granted_offset: goff_q,
						granted_bytes: gbytes_q, arena_all_free: all_free};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE) || cfg_we;
	assign done = done_q;
	assign rsp = rsp_q;
endmodule

### hdl/first_fit_block_allocator_unit_chk.sv
// Port-level checker for the first-fit allocator, bound to the top level.
// Depends on ffa_pkg and the assertion macros header.
`include "first_fit_block_allocator_unit_defines.svh"
module first_fit_block_allocator_unit_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input ffa_pkg::rsp_t rsp
);
	import ffa_pkg::*;
	`FFA_ASSERT_NEXT(a_acc_busy, clk, arst_n, start && !busy, busy, "busy not raised")
	`FFA_ASSERT_IMPL(a_done_busy, clk, arst_n, done, !busy || $past(busy), "stray done")
	`FFA_ASSERT_IMPL(a_zero_fail, clk, arst_n, done && rsp.status != ST_OK,
		rsp.granted_offset == '0 && rsp.granted_bytes == '0, "fail with grant")
	`FFA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done longer than one cycle")
endmodule

bind first_fit_block_allocator_unit first_fit_block_allocator_unit_chk u_chk (
	.clk, .arst_n, .start, .busy, .done, .rsp
);

### tb/first_fit_block_allocator_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator_unit: a built-in predictor
// mirrors the free-segment table and header store, and every result is checked.
// Depends on ffa_pkg and the allocator RTL.
module first_fit_block_allocator_unit_test;
	import ffa_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	first_fit_block_allocator_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// allocator image
	int arena_size;
	int waste_limit;
	logic [15:0] free_start [MaxSegments];
	logic [15:0] free_bytes [MaxSegments];
	int free_count;
	logic [7:0] hdr_mem [65536];
	bit hdr_known [65536];

	rsp_t pending_rsp [$];
	int live_blocks [$];
	int dead_blocks [$];
	int mismatches;
	int idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int eff_arena();
		return (arena_size < ArenaMin) ? ArenaMin : arena_size;
	endfunction

	function automatic int eff_waste();
		return (waste_limit < WasteMin) ? WasteMin : waste_limit;
	endfunction

	function automatic void put_hdr(int a, int v);
		hdr_mem[a & 16'hFFFF] = v[7:0];
		hdr_mem[(a + 1) & 16'hFFFF] = v[15:8];
		hdr_known[a & 16'hFFFF] = 1'b1;
		hdr_known[(a + 1) & 16'hFFFF] = 1'b1;
	endfunction

	function automatic int get_hdr(int a);
		return {hdr_mem[(a + 1) & 16'hFFFF], hdr_mem[a & 16'hFFFF]};
	endfunction

	function automatic void init_arena();
		for (int k = 0; k < 65536; k++) begin
			hdr_mem[k] = 8'd0;
			hdr_known[k] = 1'b0;
		end
		for (int k = 0; k < MaxSegments; k++) begin
			free_start[k] = '0;
			free_bytes[k] = '0;
		end
		free_bytes[0] = 16'(eff_arena() - HdrBytes);
		free_count = 1;
		put_hdr(0, free_bytes[0]);
		live_blocks.delete();
		dead_blocks.delete();
	endfunction

	function automatic logic [1:0] alloc_block(int rq, output int goff, output int gbytes);
		int x, i, st, b, n;
		goff = 0;
		gbytes = 0;
		if (rq == RefusedSize) return ST_NOFIT;
		x = rq + 1;
		if (x < MinPayload) x = MinPayload;
		x = x & EvenMask;
		i = 0;
		while (i < free_count && free_bytes[i] < x) i++;
		if (i >= free_count) return ST_NOFIT;
		st = free_start[i];
		b = free_bytes[i];
		n = b - x;
		if (n > eff_waste()) begin
			free_start[i] = 16'((st + x + HdrBytes) & 16'hFFFF);
			free_bytes[i] = 16'(n - HdrBytes);
			put_hdr(free_start[i], n - HdrBytes);
			put_hdr(st, x);
			gbytes = x;
		end else begin
			for (int k = i; k + 1 < free_count; k++) begin
				free_start[k] = free_start[k + 1];
				free_bytes[k] = free_bytes[k + 1];
			end
			free_count--;
			gbytes = b;
		end
		goff = (st + HdrBytes) & 16'hFFFF;
		return ST_OK;
	endfunction

	function automatic logic [1:0] release_block(int off);
		int h, s, i, blk_end;
		bit left, right;
		if (off < HdrBytes || off - HdrBytes >= eff_arena()) return ST_BADADDR;
		h = off - HdrBytes;
		s = get_hdr(h);
		i = 0;
		while (i < free_count && free_start[i] < h) i++;
		left = i > 0 && (int'(free_start[i-1]) + int'(free_bytes[i-1]) + HdrBytes == h);
		blk_end = h + s + HdrBytes;
		right = i < free_count && int'(free_start[i]) == blk_end;
		if (left && right) begin
			s = (free_bytes[i-1] + s + HdrBytes + free_bytes[i] + HdrBytes) & 16'hFFFF;
			free_bytes[i-1] = 16'(s);
			put_hdr(free_start[i-1], s);
			for (int k = i; k + 1 < free_count; k++) begin
				free_start[k] = free_start[k + 1];
				free_bytes[k] = free_bytes[k + 1];
			end
			free_count--;
		end else if (left) begin
			s = (free_bytes[i-1] + s + HdrBytes) & 16'hFFFF;
			free_bytes[i-1] = 16'(s);
			put_hdr(free_start[i-1], s);
		end else if (right) begin
			s = (s + HdrBytes + free_bytes[i]) & 16'hFFFF;
			free_start[i] = 16'(h);
			free_bytes[i] = 16'(s);
			put_hdr(h, s);
		end else begin
			if (free_count >= MaxSegments) return ST_FULL;
			for (int k = free_count; k > i; k--) begin
				free_start[k] = free_start[k - 1];
				free_bytes[k] = free_bytes[k - 1];
			end
			free_start[i] = 16'(h);
			free_bytes[i] = 16'(s);
			free_count++;
		end
		return ST_OK;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t o;
		int goff, gbytes;
		goff = 0;
		gbytes = 0;
		if (r.operation == 1'b0) begin
			o.status = alloc_block(r.request_bytes, goff, gbytes);
			if (o.status == ST_OK) live_blocks.push_back(goff);
		end else begin
			o.status = release_block(r.block_offset);
		end
		o.granted_offset = 16'(goff);
		o.granted_bytes = 16'(gbytes);
		o.arena_all_free = (free_count > 0 && int'(free_bytes[0]) + HdrBytes == eff_arena());
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				automatic rsp_t want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.granted_offset !== want.granted_offset)
					report_mismatch("granted_offset", rsp.granted_offset, want.granted_offset);
				if (rsp.granted_bytes !== want.granted_bytes)
					report_mismatch("granted_bytes", rsp.granted_bytes, want.granted_bytes);
				if (rsp.arena_all_free !== want.arena_all_free)
					report_mismatch("arena_all_free", rsp.arena_all_free, want.arena_all_free);
			end
		end
	end

	// called at a falling edge; leaves start high for a back-to-back transaction
	task automatic send_item(logic op, int rq, int off);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		start = 1'b1;
		req.operation = op;
		req.request_bytes = 16'(rq);
		req.block_offset = 16'(off);
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_rsp.push_back(predict_response(req));
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_rsp.size() > 0) @(negedge clk);
		repeat (150) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = 16'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_ARENA) begin
			arena_size = value & 16'hFFFF;
			init_arena();
		end else begin
			waste_limit = value & 8'hFF;
		end
		@(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic alloc_req(int rq);
		send_item(1'b0, rq, $urandom_range(0, 65535));
	endtask

	task automatic free_req(int off);
		send_item(1'b1, $urandom_range(0, 65535), off);
	endtask

	// a free offset whose header the allocator has written, or one outside the arena
	function automatic int safe_offset(int off);
		int h;
		h = off - HdrBytes;
		if (off >= HdrBytes && h < eff_arena() && !(hdr_known[h] && hdr_known[(h + 1) & 16'hFFFF]))
			return HdrBytes;
		return off;
	endfunction

	task automatic free_live(int idx);
		int off;
		off = live_blocks[idx];
		live_blocks.delete(idx);
		dead_blocks.push_back(off);
		free_req(off);
	endtask

	task automatic test_directed();
		alloc_req(0);
		alloc_req(1);
		alloc_req(2);
		alloc_req(3);
		alloc_req(100);
		alloc_req(RefusedSize);
		alloc_req(65534);
		alloc_req(16381);
		free_req(0);
		free_req(1);
		free_req(16386);
		free_req(65535);
		free_live(1);
		free_live(2);
		free_live(1);
		free_live(0);
		free_live(0);
		drain();
		free_req(2);
		write_reg(REG_ARENA, 16);
		alloc_req(10);
		alloc_req(0);
		free_req(2);
		free_req(18);
		drain();
	endtask

	task automatic test_table_full();
		write_reg(REG_WASTE, 4);
		write_reg(REG_ARENA, 4096);
		for (int k = 0; k < 140; k++) alloc_req(3);
		for (int k = 0; k < 70; k++) free_live(k);
		while (live_blocks.size() > 0) free_live($urandom_range(0, live_blocks.size() - 1));
	endtask

	task automatic test_random(int arena, int waste, int pct, int count);
		int roll, off;
		write_reg(REG_ARENA, arena);
		write_reg(REG_WASTE, waste);
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				if ($urandom_range(9) == 0) alloc_req($urandom_range(0, 65535));
				else if ($urandom_range(4) == 0) alloc_req($urandom_range(0, eff_arena()));
				else alloc_req($urandom_range(0, 40));
			end else if (roll < 85 && live_blocks.size() > 0) begin
				free_live($urandom_range(0, live_blocks.size() - 1));
			end else if (roll < 92 && dead_blocks.size() > 0) begin
				free_req(safe_offset(dead_blocks[$urandom_range(0, dead_blocks.size() - 1)]));
			end else begin
				off = $urandom_range(0, 65535);
				free_req(safe_offset(off));
			end
		end
		drain();
		idle_pct = 0;
	endtask

	task automatic test_config_extremes();
		write_reg(REG_ARENA, 0);
		alloc_req(11);
		alloc_req(0);
		free_req(2);
		write_reg(REG_ARENA, 5);
		write_reg(REG_WASTE, 0);
		alloc_req(5);
		alloc_req(5);
		free_req(2);
		write_reg(REG_WASTE, 255);
		write_reg(REG_ARENA, 65535);
		alloc_req(65532);
		alloc_req(0);
		free_req(2);
		free_req(65535);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ARENA;
		cfg_data = '0;
		mismatches = 0;
		idle_pct = 0;
		arena_size = ArenaReset;
		waste_limit = WasteReset;
		init_arena();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		test_directed();
		test_config_extremes();
		test_table_full();
		test_random(16384, 16, 0, 120);
		test_random(512, 4, 86, 120);
		test_random(65535, 255, 21, 120);
		test_random(200, 8, 0, 80);

		drain();
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

### first_fit_block_allocator_unit.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/first_fit_block_allocator_unit.sv
hdl/first_fit_block_allocator_unit_chk.sv
tb/first_fit_block_allocator_unit_test.sv
